// ===== rtl/core/complex_arithmetic_unit_macros.svh =====
// Assertion macros for the complex arithmetic unit.
// Included by the RTL files that carry assertions; no other dependencies.
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// clocked check, disabled while reset is high
`define CAU_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that also holds during reset
`define CAU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CAU_ASSERT(lbl, clk, rst, prop, msg)
`define CAU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/core/cau_pkg.sv =====
// Shared types and constants of the complex arithmetic unit.
// Used by the controller, the datapath and the top level; no dependencies.
package cau_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int EXP_W  = 8;
  localparam int OP_W   = 3;
  localparam int IN_W   = 5 * DATA_W + EXP_W;

  localparam logic [DATA_W-1:0] MAX_V = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MIN_V = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] ONE_V = DATA_W'(1) << FRAC_W;

  typedef enum logic [OP_W-1:0] {
    OP_CONJ  = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MUL   = 3'd3,
    OP_SCALE = 3'd4,
    OP_POWER = 3'd5,
    OP_MODSQ = 3'd6
  } op_t;

  typedef struct packed {
    logic       load;
    logic       mul_go;
    logic [1:0] mul_idx;
    logic       comb;
    logic       push;
  } cau_cmd_t;

  typedef struct packed {
    logic needs_mul;
    logic two_prod;
    logic again;
  } cau_sts_t;

endpackage

// ===== rtl/core/cau_datapath.sv =====
// Datapath of the complex arithmetic unit: operand registers, one shared
// multiplier, product registers, saturating adder and output register. Uses cau_pkg.
module cau_datapath
  import cau_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cau_cmd_t                 cmd,
  input  logic [OP_W-1:0]          in_op,
  input  logic [IN_W-1:0]          in_data,
  output cau_sts_t                 sts,
  output logic [DATA_W-1:0]        out_re,
  output logic [DATA_W-1:0]        out_im,
  output logic                     out_ovf
);

  function automatic logic [DATA_W:0] fmul_sat(input logic signed [2*DATA_W-1:0] pr);
    logic signed [2*DATA_W-1:0] sh;
    logic [DATA_W:0] r;
    sh = pr >>> FRAC_W;
    if ((&sh[2*DATA_W-1:DATA_W-1]) || !(|sh[2*DATA_W-1:DATA_W-1])) begin
      r = {1'b0, sh[DATA_W-1:0]};
    end else if (sh[2*DATA_W-1]) begin
      r = {1'b1, MIN_V};
    end else begin
      r = {1'b1, MAX_V};
    end
    return r;
  endfunction

  function automatic logic [DATA_W:0] clamp(input logic [DATA_W:0] s);
    logic [DATA_W:0] r;
    if (s[DATA_W] != s[DATA_W-1]) begin
      r = {1'b1, (s[DATA_W] ? MIN_V : MAX_V)};
    end else begin
      r = {1'b0, s[DATA_W-1:0]};
    end
    return r;
  endfunction

  function automatic logic [DATA_W:0] sat_add(input logic [DATA_W-1:0] a,
                                               input logic [DATA_W-1:0] b);
    return clamp({a[DATA_W-1], a} + {b[DATA_W-1], b});
  endfunction

  function automatic logic [DATA_W:0] sat_sub(input logic [DATA_W-1:0] a,
                                               input logic [DATA_W-1:0] b);
    return clamp({a[DATA_W-1], a} - {b[DATA_W-1], b});
  endfunction

  logic [DATA_W-1:0] a_re, a_im, b_re, b_im, s_f;
  logic [EXP_W-1:0]  e_in;

  assign a_re = in_data[0*DATA_W +: DATA_W];
  assign a_im = in_data[1*DATA_W +: DATA_W];
  assign b_re = in_data[2*DATA_W +: DATA_W];
  assign b_im = in_data[3*DATA_W +: DATA_W];
  assign s_f  = in_data[4*DATA_W +: DATA_W];
  assign e_in = in_data[5*DATA_W +: EXP_W];

  op_t               op;
  logic [DATA_W-1:0] cur_re, cur_im, y_re, y_im;
  logic [EXP_W-1:0]  iter;
  logic              exp_zero;
  logic              ovf;

  logic signed [2*DATA_W-1:0] prod;
  logic [1:0]                 prod_idx;
  logic                       prod_vld;
  logic [DATA_W-1:0]          p [4];

  logic signed [DATA_W-1:0] mx, my;
  logic [DATA_W:0]          fm;
  logic [DATA_W:0]          t_re, t_im;
  logic [DATA_W-1:0]        n_re, n_im;
  logic                     n_ovf;
  logic                     pow_loop;

  assign mx = cmd.mul_idx[0] ? cur_im : cur_re;
  assign my = (cmd.mul_idx[0] ^ cmd.mul_idx[1]) ? y_im : y_re;
  assign fm = fmul_sat(prod);
  assign pow_loop = (op == OP_POWER) && (iter != '0);

  assign sts.needs_mul = (op == OP_MUL) || (op == OP_SCALE) || (op == OP_MODSQ) || pow_loop;
  assign sts.two_prod  = (op == OP_SCALE) || (op == OP_MODSQ);
  assign sts.again     = (op == OP_POWER) && (iter > EXP_W'(1));

  always_comb begin
    t_re  = '0;
    t_im  = '0;
    n_re  = '0;
    n_im  = '0;
    n_ovf = 1'b0;
    case (op) inside
      OP_CONJ: begin
        t_im  = sat_sub('0, cur_im);
        n_re  = cur_re;
        n_im  = t_im[DATA_W-1:0];
        n_ovf = t_im[DATA_W];
      end
      OP_ADD: begin
        t_re  = sat_add(cur_re, y_re);
        t_im  = sat_add(cur_im, y_im);
        n_re  = t_re[DATA_W-1:0];
        n_im  = t_im[DATA_W-1:0];
        n_ovf = t_re[DATA_W] | t_im[DATA_W];
      end
      OP_SUB: begin
        t_re  = sat_sub(cur_re, y_re);
        t_im  = sat_sub(cur_im, y_im);
        n_re  = t_re[DATA_W-1:0];
        n_im  = t_im[DATA_W-1:0];
        n_ovf = t_re[DATA_W] | t_im[DATA_W];
      end
      OP_MUL, OP_POWER: begin
        if ((op == OP_MUL) || pow_loop) begin
          t_re  = sat_sub(p[0], p[1]);
          t_im  = sat_add(p[2], p[3]);
          n_re  = t_re[DATA_W-1:0];
          n_im  = t_im[DATA_W-1:0];
          n_ovf = t_re[DATA_W] | t_im[DATA_W];
        end else if (exp_zero) begin
          n_re = ONE_V;
          n_im = '0;
        end else begin
          n_re = cur_re;
          n_im = cur_im;
        end
      end
      OP_SCALE: begin
        n_re = p[0];
        n_im = p[1];
      end
      OP_MODSQ: begin
        t_re  = sat_add(p[0], p[1]);
        n_re  = t_re[DATA_W-1:0];
        n_im  = '0;
        n_ovf = t_re[DATA_W];
      end
      default: begin
        n_re = '0;
        n_im = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= cmd.mul_go;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      prod     <= mx * my;
      prod_idx <= cmd.mul_idx;
    end
    if (prod_vld) begin
      p[prod_idx] <= fm[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= op_t'(in_op);
      cur_re   <= a_re;
      cur_im   <= a_im;
      exp_zero <= (e_in == '0);
      ovf      <= 1'b0;
      iter     <= '0;
      case (op_t'(in_op)) inside
        OP_SCALE: begin
          y_re <= s_f;
          y_im <= s_f;
        end
        OP_POWER, OP_MODSQ: begin
          y_re <= a_re;
          y_im <= a_im;
          if ((op_t'(in_op) == OP_POWER) && (e_in != '0)) begin
            iter <= e_in - EXP_W'(1);
          end
        end
        default: begin
          y_re <= b_re;
          y_im <= b_im;
        end
      endcase
    end else begin
      if (prod_vld) begin
        ovf <= ovf | fm[DATA_W];
      end
      if (cmd.comb) begin
        cur_re <= n_re;
        cur_im <= n_im;
        ovf    <= ovf | n_ovf;
        if (pow_loop) begin
          iter <= iter - EXP_W'(1);
        end
      end
    end
    if (cmd.push) begin
      out_re  <= cur_re;
      out_im  <= cur_im;
      out_ovf <= ovf;
    end
  end

endmodule

// ===== rtl/core/cau_ctrl.sv =====
// Controller of the complex arithmetic unit: one-hot sequencer that issues
// load, multiply, combine and push commands. Uses cau_pkg and the macro header.
`include "complex_arithmetic_unit_macros.svh"

module cau_ctrl
  import cau_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  input  cau_sts_t sts,
  output cau_cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_DISPATCH = 6'b000010,
    ST_MUL      = 6'b000100,
    ST_DRAIN    = 6'b001000,
    ST_COMB     = 6'b010000,
    ST_DONE     = 6'b100000
  } state_t;

  state_t     state, state_next;
  logic [1:0] cnt, cnt_next;
  logic       mul_last;
  logic       slot_free;

  assign s_tready  = (state == ST_IDLE);
  assign slot_free = !m_tvalid || m_tready;
  assign mul_last  = sts.two_prod ? (cnt == 2'd1) : (cnt == 2'd3);

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    cmd         = '0;
    cmd.mul_idx = cnt;
    unique case (state)
      ST_IDLE: begin
        cmd.load = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cnt_next   = '0;
        state_next = sts.needs_mul ? ST_MUL : ST_COMB;
      end
      ST_MUL: begin
        cmd.mul_go = 1'b1;
        if (mul_last) begin
          cnt_next   = '0;
          state_next = ST_DRAIN;
        end else begin
          cnt_next = cnt + 2'd1;
        end
      end
      ST_DRAIN: begin
        state_next = ST_COMB;
      end
      ST_COMB: begin
        cmd.comb   = 1'b1;
        state_next = sts.again ? ST_MUL : ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.push) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `CAU_ASSERT(a_push_slot, clk, rst, cmd.push |-> slot_free, "push into occupied output")
  `CAU_ASSERT(a_accept_dispatch, clk, rst, (s_tvalid && s_tready) |=> (state == ST_DISPATCH), "accept not followed by dispatch")
  `CAU_ASSERT(a_two_prod_cnt, clk, rst, ((state == ST_MUL) && sts.two_prod) |-> (cnt <= 2'd1), "extra product issued")
  `CAU_ASSERT(a_drain_comb, clk, rst, (state == ST_DRAIN) |=> (state == ST_COMB), "drain not followed by combine")

endmodule

// ===== rtl/core/complex_arithmetic_unit.sv =====
// Top level of the complex arithmetic unit: Q16.16 complex ALU.
// Instantiates cau_ctrl and cau_datapath; uses cau_pkg.
//
// Input channel s_*: one item per operation, opcode in s_tuser. Output channel
// m_*: one result item per input item, in order, overflow flag in m_tuser.
// One item is in work at a time; s_tready is high only while the sequencer
// is idle, so the next item can be accepted in the cycle after the push. Each
// complex multiply takes four passes of the single registered 32x32 multiplier
// plus a drain and a combine state. A finished result sits in the output
// register; the next item is accepted while it waits, and only its own push
// waits for the slot to free up. Reset (rst, synchronous) clears the
// sequencer and m_tvalid; no item is kept across reset.
module complex_arithmetic_unit
  import cau_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // a_re, a_im, b_re, b_im, scale_factor, exponent
  input  logic [IN_W-1:0]     s_tdata,
  // opcode
  input  logic [OP_W-1:0]     s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // result_re, result_im
  output logic [2*DATA_W-1:0] m_tdata,
  // overflow
  output logic                m_tuser
);

  cau_cmd_t          cmd;
  cau_sts_t          sts;
  logic [DATA_W-1:0] out_re, out_im;

  cau_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cau_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .in_op   (s_tuser),
    .in_data (s_tdata),
    .sts     (sts),
    .out_re  (out_re),
    .out_im  (out_im),
    .out_ovf (m_tuser)
  );

  assign m_tdata = {out_im, out_re};

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for complex_arithmetic_unit: directed corner items, then
// random traffic with idle gaps on both streams or none, results checked in order.
// Depends on cau_pkg and the complex_arithmetic_unit RTL.
module tb;
  import cau_pkg::*;

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  typedef struct {
    logic [DATA_W-1:0] re;
    logic [DATA_W-1:0] im;
    logic              ovf;
  } cau_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata = '0;
  logic [OP_W-1:0]     s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [2*DATA_W-1:0] m_tdata;
  logic                m_tuser;

  cau_result_t expected_results[$];
  cau_result_t head_result;
  int          mismatches = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          sat_hit;

  complex_arithmetic_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #6 clk = ~clk;

  // saturating Q16.16 arithmetic
  function automatic longint clamp_word(input longint v);
    if (v > WORD_MAX) begin
      sat_hit = 1'b1;
      return WORD_MAX;
    end
    if (v < WORD_MIN) begin
      sat_hit = 1'b1;
      return WORD_MIN;
    end
    return v;
  endfunction

  function automatic longint fx_mul(input longint a, input longint b);
    return clamp_word((a * b) >>> FRAC_W);
  endfunction

  function automatic void cplx_mul(input longint ar, input longint ai, input longint br,
                                   input longint bi, output longint rr, output longint ri);
    rr = clamp_word(fx_mul(ar, br) - fx_mul(ai, bi));
    ri = clamp_word(fx_mul(ar, bi) + fx_mul(ai, br));
  endfunction

  function automatic cau_result_t predict_cau(input logic [OP_W-1:0] op,
                                              input logic signed [DATA_W-1:0] ar,
                                              input logic signed [DATA_W-1:0] ai,
                                              input logic signed [DATA_W-1:0] br,
                                              input logic signed [DATA_W-1:0] bi,
                                              input logic signed [DATA_W-1:0] sf,
                                              input logic [EXP_W-1:0] e);
    cau_result_t r;
    longint      rr;
    longint      ri;
    longint      pr;
    longint      pi;
    int          k;
    sat_hit = 1'b0;
    rr = 0;
    ri = 0;
    case (op)
      OP_CONJ: begin
        rr = ar;
        ri = clamp_word(0 - longint'(ai));
      end
      OP_ADD: begin
        rr = clamp_word(longint'(ar) + longint'(br));
        ri = clamp_word(longint'(ai) + longint'(bi));
      end
      OP_SUB: begin
        rr = clamp_word(longint'(ar) - longint'(br));
        ri = clamp_word(longint'(ai) - longint'(bi));
      end
      OP_MUL: cplx_mul(ar, ai, br, bi, rr, ri);
      OP_SCALE: begin
        rr = fx_mul(ar, sf);
        ri = fx_mul(ai, sf);
      end
      OP_POWER: begin
        if (e == 0) begin
          rr = longint'(ONE_V);
          ri = 0;
        end else begin
          rr = ar;
          ri = ai;
          for (k = 1; k < e; k++) begin
            cplx_mul(rr, ri, ar, ai, pr, pi);
            rr = pr;
            ri = pi;
          end
        end
      end
      OP_MODSQ: begin
        rr = clamp_word(fx_mul(ar, ar) + fx_mul(ai, ai));
        ri = 0;
      end
      default: ;
    endcase
    r.re  = rr[DATA_W-1:0];
    r.im  = ri[DATA_W-1:0];
    r.ovf = sat_hit;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
    $display("mismatch at cycle %0d: %s expected %h got %h", cycles, what, want, got);
    mismatches++;
  endtask

  task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] ar,
                           input logic [DATA_W-1:0] ai, input logic [DATA_W-1:0] br,
                           input logic [DATA_W-1:0] bi, input logic [DATA_W-1:0] sf,
                           input logic [EXP_W-1:0] e);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {e, sf, bi, br, ai, ar};
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(predict_cau(op, ar, ai, br, bi, sf, e));
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(9))
      0, 1, 2: return $urandom;
      3: begin
        case ($urandom_range(6))
          0: return MAX_V;
          1: return MIN_V;
          2: return '0;
          3: return '1;
          4: return 1;
          5: return ONE_V;
          default: return -ONE_V;
        endcase
      end
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  // near unit circle keeps long powers from pinning at the rails
  function automatic logic [DATA_W-1:0] rand_unit_word();
    return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
  endfunction

  task automatic send_random_item();
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] ar;
    logic [DATA_W-1:0] ai;
    logic [EXP_W-1:0]  e;
    op = ($urandom_range(99) == 0) ? OP_UNUSED : OP_W'($urandom_range(0, 6));
    ar = rand_word();
    ai = rand_word();
    e  = ($urandom_range(9) == 0) ? EXP_W'($urandom_range(0, 255))
                                  : EXP_W'($urandom_range(0, 12));
    if (op == OP_POWER && $urandom_range(3) != 0) begin
      ar = rand_unit_word();
      ai = rand_unit_word();
    end
    send_item(op, ar, ai, rand_word(), rand_word(), rand_word(), e);
  endtask

  task automatic test_directed();
    send_item(OP_CONJ, MAX_V, MIN_V, 0, 0, 0, 8'd0);
    send_item(OP_CONJ, MIN_V, MAX_V, '1, '1, '1, '1);
    send_item(OP_ADD, MAX_V, MAX_V, 1, 1, 0, 8'd0);
    send_item(OP_ADD, MIN_V, MIN_V, '1, '1, 0, 8'd0);
    send_item(OP_ADD, 32'h0001_8000, -32'h0000_4000, 32'h0002_0000, 32'h0000_4000, 0, 8'd0);
    send_item(OP_SUB, MIN_V, MAX_V, 1, MIN_V, 0, 8'd0);
    send_item(OP_SUB, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000, 0, 8'd0);
    send_item(OP_MUL, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, -32'h0001_0000, 0, 8'd0);
    send_item(OP_MUL, MIN_V, MIN_V, MIN_V, MIN_V, 0, 8'd0);
    send_item(OP_MUL, MAX_V, MIN_V, MAX_V, MIN_V, 0, 8'd0);
    send_item(OP_SCALE, 32'h0004_0000, -32'h0002_0000, 0, 0, MIN_V, 8'd0);
    // tiny negative product rounds down
    send_item(OP_SCALE, 1, -1, 0, 0, '1, 8'd0);
    send_item(OP_SCALE, MAX_V, MIN_V, 0, 0, MAX_V, 8'd0);
    send_item(OP_POWER, 32'h0002_0000, 32'h0001_0000, 0, 0, 0, 8'd0);
    send_item(OP_POWER, MIN_V, MAX_V, 0, 0, 0, 8'd1);
    send_item(OP_POWER, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, 8'd2);
    send_item(OP_POWER, 32'h0000_b505, 32'h0000_b505, 0, 0, 0, 8'd255);
    send_item(OP_POWER, 32'h0002_0000, 0, 0, 0, 0, 8'd255);
    send_item(OP_POWER, 32'h0000_ffff, -32'h0000_0100, 0, 0, 0, 8'd128);
    send_item(OP_MODSQ, MIN_V, MIN_V, '1, '1, '1, 8'd0);
    send_item(OP_MODSQ, 32'h0003_8000, -32'h0002_0000, 0, 0, 0, 8'd0);
    send_item(OP_UNUSED, '1, '1, '1, '1, '1, '1);
    send_item(OP_UNUSED, 0, 0, 0, 0, 0, 8'd0);
  endtask

  task automatic test_random_traffic(input int n_items, input int send_pct,
                                     input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (n_items) send_random_item();
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected item re", '0, m_tdata[DATA_W-1:0]);
      end else begin
        head_result = expected_results.pop_front();
        if (m_tdata[DATA_W-1:0] !== head_result.re)
          report_mismatch("result_re", head_result.re, m_tdata[DATA_W-1:0]);
        if (m_tdata[2*DATA_W-1:DATA_W] !== head_result.im)
          report_mismatch("result_im", head_result.im, m_tdata[2*DATA_W-1:DATA_W]);
        if (m_tuser !== head_result.ovf)
          report_mismatch("overflow", DATA_W'(head_result.ovf), DATA_W'(m_tuser));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    send_idle_pct = 31;
    recv_idle_pct = 48;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_traffic(630, 31, 48);
    wait_for_results();
    test_random_traffic(630, 48, 31);
    wait_for_results();
    test_random_traffic(630, 0, 0);
    wait_for_results();
    repeat (30) @(posedge clk);
    if (mismatches == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
